>>> rtl/fbmv_pkg.sv
`timescale 1ns / 1ps
package fbmv_pkg;

  // Noise configuration
  localparam int OCTAVES = 4;
  localparam int OCT_W   = (OCTAVES > 1) ? $clog2(OCTAVES) : 1;

  // Field widths
  localparam int DIR_W  = 16;
  localparam int PT_W   = 18;
  localparam int VAL_W  = 24;
  localparam int SUM_W  = VAL_W + OCTAVES;
  localparam int V_W    = 34 + OCTAVES;
  localparam int BP_W   = 43;
  localparam int ADDR_W = 4;

  // Lattice hash constants
  localparam logic [31:0] H_MUL1    = 32'h7feb352d;
  localparam logic [31:0] H_MUL2    = 32'h846ca68b;
  localparam logic [31:0] H_GOLD    = 32'h9e3779b9;
  localparam logic [31:0] H_CX      = 32'hc2b2ae35;
  localparam logic [31:0] H_CY      = 32'h27d4eb2f;
  localparam logic [31:0] H_CZ      = 32'h165667b1;
  localparam logic [31:0] SEED_STEP = 32'd131;

  // Fixed-point constants
  localparam logic signed [V_W-1:0] FREQ_Q16   = V_W'(150733);
  localparam logic signed [41:0]    AMP2_Q16   = 42'sd39322;
  localparam logic [33:0]           SQUASH_Q16 = 34'd36045;
  localparam logic [49:0]           CROWN_Q16  = 50'd66454;
  localparam logic [16:0]           ONE_Q16    = 17'd65536;

  // Register indexes
  localparam logic [1:0] CFG_SEED = 2'd0;
  localparam logic [1:0] CFG_SIZE = 2'd1;
  localparam logic [1:0] CFG_FLAT = 2'd2;

  // Reset values
  localparam logic [31:0] SEED_RST = 32'd5;
  localparam logic [15:0] SIZE_RST = 16'd256;
  localparam logic [16:0] FLAT_RST = 17'd0;

  // Data handed from cell to cell
  typedef struct packed {
    logic signed [DIR_W-1:0] dir_x;
    logic signed [DIR_W-1:0] dir_y;
    logic signed [DIR_W-1:0] dir_z;
    logic [SUM_W-1:0]        sum;
  } cell_data_t;

  function automatic logic [31:0] xs16(input logic [31:0] h);
    return h ^ (h >> 16);
  endfunction

  function automatic logic [31:0] xs15(input logic [31:0] h);
    return h ^ (h >> 15);
  endfunction

  // (b - a) * s for a lerp step
  function automatic logic signed [BP_W-1:0] bl_mul(input logic [VAL_W-1:0] a,
                                                   input logic [VAL_W-1:0] b,
                                                   input logic [16:0] s);
    logic signed [BP_W-1:0] dd;
    logic signed [BP_W-1:0] ss;
    dd = BP_W'($signed({1'b0, b})) - BP_W'($signed({1'b0, a}));
    ss = BP_W'($signed({1'b0, s}));
    return dd * ss;
  endfunction

  // a + floor(p / 2^16)
  function automatic logic [VAL_W-1:0] lerp(input logic [VAL_W-1:0] a,
                                            input logic signed [BP_W-1:0] p);
    logic signed [BP_W-1:0] r;
    r = BP_W'($signed({1'b0, a})) + (p >>> 16);
    return r[VAL_W-1:0];
  endfunction

endpackage

>>> rtl/fbmv_in_if.sv
`timescale 1ns / 1ps
interface fbmv_in_if import fbmv_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [DIR_W-1:0] dir_x;
  logic signed [DIR_W-1:0] dir_y;
  logic signed [DIR_W-1:0] dir_z;

  modport source (output valid, output dir_x, output dir_y, output dir_z, input ready);
  modport sink (input valid, input dir_x, input dir_y, input dir_z, output ready);
endinterface

>>> rtl/fbmv_out_if.sv
`timescale 1ns / 1ps
interface fbmv_out_if import fbmv_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic signed [PT_W-1:0] point_x;
  logic signed [PT_W-1:0] point_y;
  logic signed [PT_W-1:0] point_z;

  modport source (output valid, output point_x, output point_y, output point_z,
                  input ready);
  modport sink (input valid, input point_x, input point_y, input point_z,
                output ready);
endinterface

>>> rtl/fbmv_cell.sv
`timescale 1ns / 1ps
module fbmv_cell import fbmv_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [OCT_W-1:0] oct_idx,
  input  logic [31:0]      seed,
  input  logic             up_valid,
  output logic             up_ready,
  input  cell_data_t       up_data,
  output logic             dn_valid,
  input  logic             dn_ready,
  output cell_data_t       dn_data
);

  localparam int NST = 12;

  typedef struct packed {
    logic [16:0] sx;
    logic [16:0] sy;
    logic [16:0] sz;
  } ease_t;

  typedef struct packed {
    logic [31:0] x0;
    logic [31:0] x1;
    logic [31:0] y0;
    logic [31:0] y1;
    logic [31:0] z0;
    logic [31:0] z1;
  } cprod_t;

  // smoothstep t*t*(3-2t), t2 = t*t already scaled
  function automatic logic [16:0] smooth(input logic [15:0] t, input logic [15:0] t2);
    logic [33:0] w;
    logic [33:0] p;
    w = 34'd196608 - 34'({t, 1'b0});
    p = 34'(t2) * w;
    return p[32:16];
  endfunction

  function automatic logic [15:0] sq16(input logic [15:0] t);
    logic [31:0] p;
    p = {16'b0, t} * {16'b0, t};
    return p[31:16];
  endfunction

  logic [NST-1:0] v_r;
  logic [NST:0]   en;

  // per-octave seed, premultiplied
  logic [31:0] seedo_r, seedh_r;

  cell_data_t pass_r [NST-1];

  logic signed [V_W-1:0] vx_r, vy_r, vz_r;
  cprod_t cp_r [1:5];
  logic [15:0] tx_r, ty_r, tz_r, t2x_r, t2y_r, t2z_r;
  ease_t ease_r [2:9];
  logic [31:0] h2_r [2];
  logic [31:0] h3_r [2];
  logic [31:0] h4_r [4];
  logic [31:0] h5_r [4];
  logic [31:0] h6_r [8];
  logic [31:0] h7_r [8];
  logic signed [BP_W-1:0] bp8_r [4];
  logic [VAL_W-1:0]       a8_r [4];
  logic signed [BP_W-1:0] bp9_r [2];
  logic [VAL_W-1:0]       a9_r [2];
  logic signed [BP_W-1:0] bp10_r;
  logic [VAL_W-1:0]       a10_r;
  cell_data_t dn_r;

  // stall chain: a stage moves when empty or when the next one moves
  always_comb begin
    en[NST] = dn_ready;
    for (int k = NST - 1; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign up_ready = en[0];
  assign dn_valid = v_r[NST-1];
  assign dn_data  = dn_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= up_valid;
      for (int k = 1; k < NST; k++) begin
        if (en[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    seedo_r <= seed + 32'(oct_idx) * SEED_STEP;
    seedh_r <= seedo_r * H_GOLD;
  end

  // pass-through of direction and running sum
  always_ff @(posedge clk) begin
    if (en[0]) pass_r[0] <= up_data;
    for (int k = 1; k < NST - 1; k++) begin
      if (en[k]) pass_r[k] <= pass_r[k-1];
    end
  end

  // stage 0: lattice coordinates
  always_ff @(posedge clk) begin
    if (en[0]) begin
      vx_r <= (V_W'(up_data.dir_x) * FREQ_Q16) <<< oct_idx;
      vy_r <= (V_W'(up_data.dir_y) * FREQ_Q16) <<< oct_idx;
      vz_r <= (V_W'(up_data.dir_z) * FREQ_Q16) <<< oct_idx;
    end
  end

  // stage 1: cell index products, fraction squares
  logic [31:0] ix, iy, iz;
  assign ix = 32'(vx_r >>> 30);
  assign iy = 32'(vy_r >>> 30);
  assign iz = 32'(vz_r >>> 30);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      cp_r[1].x0 <= ix * H_CX;
      cp_r[1].x1 <= (ix + 32'd1) * H_CX;
      cp_r[1].y0 <= iy * H_CY;
      cp_r[1].y1 <= (iy + 32'd1) * H_CY;
      cp_r[1].z0 <= iz * H_CZ;
      cp_r[1].z1 <= (iz + 32'd1) * H_CZ;
      tx_r  <= vx_r[29:14];
      ty_r  <= vy_r[29:14];
      tz_r  <= vz_r[29:14];
      t2x_r <= sq16(vx_r[29:14]);
      t2y_r <= sq16(vy_r[29:14]);
      t2z_r <= sq16(vz_r[29:14]);
    end
  end

  // stage 2: fold x, first scramble multiply; smoothstep weights
  always_ff @(posedge clk) begin
    if (en[2]) begin
      h2_r[0]      <= xs16(seedh_r ^ cp_r[1].x0) * H_MUL1;
      h2_r[1]      <= xs16(seedh_r ^ cp_r[1].x1) * H_MUL1;
      cp_r[2]      <= cp_r[1];
      ease_r[2].sx <= smooth(tx_r, t2x_r);
      ease_r[2].sy <= smooth(ty_r, t2y_r);
      ease_r[2].sz <= smooth(tz_r, t2z_r);
    end
  end

  // stage 3
  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int j = 0; j < 2; j++) h3_r[j] <= xs15(h2_r[j]) * H_MUL2;
      cp_r[3]   <= cp_r[2];
      ease_r[3] <= ease_r[2];
    end
  end

  // stage 4: fold y, index k*2+j
  always_ff @(posedge clk) begin
    if (en[4]) begin
      for (int j = 0; j < 2; j++) begin
        h4_r[j]     <= xs16(xs16(h3_r[j]) ^ cp_r[3].y0) * H_MUL1;
        h4_r[2 + j] <= xs16(xs16(h3_r[j]) ^ cp_r[3].y1) * H_MUL1;
      end
      cp_r[4]   <= cp_r[3];
      ease_r[4] <= ease_r[3];
    end
  end

  // stage 5
  always_ff @(posedge clk) begin
    if (en[5]) begin
      for (int j = 0; j < 4; j++) h5_r[j] <= xs15(h4_r[j]) * H_MUL2;
      cp_r[5]   <= cp_r[4];
      ease_r[5] <= ease_r[4];
    end
  end

  // stage 6: fold z, index l*4+k*2+j
  always_ff @(posedge clk) begin
    if (en[6]) begin
      for (int j = 0; j < 4; j++) begin
        h6_r[j]     <= xs16(xs16(h5_r[j]) ^ cp_r[5].z0) * H_MUL1;
        h6_r[4 + j] <= xs16(xs16(h5_r[j]) ^ cp_r[5].z1) * H_MUL1;
      end
      ease_r[6] <= ease_r[5];
    end
  end

  // stage 7
  always_ff @(posedge clk) begin
    if (en[7]) begin
      for (int j = 0; j < 8; j++) h7_r[j] <= xs15(h6_r[j]) * H_MUL2;
      ease_r[7] <= ease_r[6];
    end
  end

  // stage 8: corner values, lerp along x
  logic [VAL_W-1:0] corner [8];
  always_comb begin
    for (int j = 0; j < 8; j++) corner[j] = VAL_W'(xs16(h7_r[j]) & 32'hffffff);
  end

  always_ff @(posedge clk) begin
    if (en[8]) begin
      for (int p = 0; p < 4; p++) begin
        a8_r[p]  <= corner[2*p];
        bp8_r[p] <= bl_mul(corner[2*p], corner[2*p + 1], ease_r[7].sx);
      end
      ease_r[8] <= ease_r[7];
    end
  end

  // stage 9: lerp along y
  logic [VAL_W-1:0] xl [4];
  always_comb begin
    for (int p = 0; p < 4; p++) xl[p] = lerp(a8_r[p], bp8_r[p]);
  end

  always_ff @(posedge clk) begin
    if (en[9]) begin
      for (int l = 0; l < 2; l++) begin
        a9_r[l]  <= xl[2*l];
        bp9_r[l] <= bl_mul(xl[2*l], xl[2*l + 1], ease_r[8].sy);
      end
      ease_r[9] <= ease_r[8];
    end
  end

  // stage 10: lerp along z
  logic [VAL_W-1:0] yl0, yl1;
  assign yl0 = lerp(a9_r[0], bp9_r[0]);
  assign yl1 = lerp(a9_r[1], bp9_r[1]);

  always_ff @(posedge clk) begin
    if (en[10]) begin
      a10_r  <= yl0;
      bp10_r <= bl_mul(yl0, yl1, ease_r[9].sz);
    end
  end

  // stage 11: weighted accumulate
  logic [VAL_W-1:0] nval;
  logic [OCT_W-1:0] wsh;
  assign nval = lerp(a10_r, bp10_r);
  assign wsh  = OCT_W'(OCTAVES - 1) - oct_idx;

  always_ff @(posedge clk) begin
    if (en[11]) begin
      dn_r.dir_x <= pass_r[NST-2].dir_x;
      dn_r.dir_y <= pass_r[NST-2].dir_y;
      dn_r.dir_z <= pass_r[NST-2].dir_z;
      dn_r.sum   <= pass_r[NST-2].sum + (SUM_W'(nval) << wsh);
    end
  end

endmodule

>>> rtl/fbmv_post.sv
`timescale 1ns / 1ps
module fbmv_post import fbmv_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [15:0]            rock_size,
  input  logic [16:0]            flatness,
  input  logic                   up_valid,
  output logic                   up_ready,
  input  cell_data_t             up_data,
  output logic                   dn_valid,
  input  logic                   dn_ready,
  output logic signed [PT_W-1:0] point_x,
  output logic signed [PT_W-1:0] point_y,
  output logic signed [PT_W-1:0] point_z
);

  localparam int NST      = 7;
  localparam int DIV      = (1 << OCTAVES) - 1;
  localparam int SHIFT    = SUM_W + OCTAVES;
  localparam int RECIP_W  = SHIFT - OCTAVES + 2;
  localparam int FM_W     = SUM_W + RECIP_W;
  localparam logic [63:0] RECIP64 = ((64'd1 << SHIFT) + 64'(DIV) - 64'd1) / 64'(DIV);
  localparam logic [RECIP_W-1:0] RECIP = RECIP64[RECIP_W-1:0];
  localparam int SC_W     = 43;
  localparam int PX_W     = SC_W + DIR_W;

  // round half up to Q8.8 and saturate
  function automatic logic signed [PT_W-1:0] emit(input logic signed [31:0] v);
    logic signed [32:0] r;
    r = (33'(v) + 33'sd128) >>> 8;
    if (r > 33'sd131071) r = 33'sd131071;
    if (r < -33'sd131072) r = -33'sd131072;
    return r[PT_W-1:0];
  endfunction

  logic [NST-1:0] v_r;
  logic [NST:0]   en;

  // config-derived terms, settled through flat_r, k_r, sk_r and top_r in turn after a write
  logic [16:0] flat_r, k_r;
  logic [32:0] sk_r;
  logic [25:0] top_r;
  logic [33:0] kq;
  logic [49:0] tp;

  assign kq = (34'(flat_r) * SQUASH_Q16 + 34'd32768) >> 16;
  assign tp = 50'(sk_r) * CROWN_Q16;

  always_ff @(posedge clk) begin
    flat_r <= (flatness > ONE_Q16) ? ONE_Q16 : flatness;
    k_r    <= ONE_Q16 - kq[16:0];
    sk_r   <= 33'(rock_size) * 33'(k_r);
    top_r  <= tp[49:24];
  end

  always_comb begin
    en[NST] = dn_ready;
    for (int k = NST - 1; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign up_ready = en[0];
  assign dn_valid = v_r[NST-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= up_valid;
      for (int k = 1; k < NST; k++) begin
        if (en[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  logic signed [DIR_W-1:0] dx_r [3], dy_r [3], dz_r [3];

  // direction carried through the radius stages
  always_ff @(posedge clk) begin
    if (en[0]) begin
      dx_r[0] <= up_data.dir_x;
      dy_r[0] <= up_data.dir_y;
      dz_r[0] <= up_data.dir_z;
    end
    for (int k = 1; k < 3; k++) begin
      if (en[k]) begin
        dx_r[k] <= dx_r[k-1];
        dy_r[k] <= dy_r[k-1];
        dz_r[k] <= dz_r[k-1];
      end
    end
  end

  // P0: sum / (2^OCTAVES - 1) by reciprocal
  logic [FM_W-1:0] fm_r;
  always_ff @(posedge clk) begin
    if (en[0]) fm_r <= FM_W'(up_data.sum) * FM_W'(RECIP);
  end

  // P1: amplitude product
  logic [VAL_W-1:0]   fbm;
  logic signed [24:0] fc;
  logic signed [41:0] g_r;
  assign fbm = fm_r[SHIFT +: VAL_W];
  assign fc  = $signed({1'b0, fbm}) - 25'sd8388608;

  always_ff @(posedge clk) begin
    if (en[1]) g_r <= 42'(fc) * AMP2_Q16;
  end

  // P2: radius scale
  logic signed [26:0]     factor;
  logic signed [SC_W-1:0] scale_r;
  assign factor = 27'sd16777216 + 27'(g_r >>> 16);

  always_ff @(posedge clk) begin
    if (en[2]) scale_r <= SC_W'($signed({1'b0, rock_size})) * SC_W'(factor);
  end

  // P3: direction times radius
  logic signed [PX_W-1:0] px_r, py_r, pz_r;
  always_ff @(posedge clk) begin
    if (en[3]) begin
      px_r <= PX_W'(dx_r[2]) * PX_W'(scale_r);
      py_r <= PX_W'(dy_r[2]) * PX_W'(scale_r);
      pz_r <= PX_W'(dz_r[2]) * PX_W'(scale_r);
    end
  end

  // P4: x, z final; y squash product
  logic signed [31:0] y4;
  logic signed [49:0] ysq_r;
  logic signed [PT_W-1:0] ex_r [4:6], ez_r [4:6];
  assign y4 = 32'(py_r >>> 30);

  always_ff @(posedge clk) begin
    if (en[4]) begin
      ex_r[4] <= emit(32'(px_r >>> 30));
      ez_r[4] <= emit(32'(pz_r >>> 30));
      ysq_r   <= 50'(y4) * 50'($signed({1'b0, k_r}));
    end
  end

  // P5: crown test and pull product
  logic signed [31:0] y5, tops, dy;
  logic signed [31:0] y5_r, top5_r;
  logic               cond5_r;
  logic signed [49:0] pr5_r;
  assign y5   = 32'(ysq_r >>> 16);
  assign tops = $signed({6'b0, top_r});
  assign dy   = y5 - tops;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      y5_r    <= y5;
      top5_r  <= tops;
      cond5_r <= (flat_r != 17'd0) && (y5 > tops);
      pr5_r   <= 50'(dy) * 50'($signed({1'b0, ONE_Q16 - flat_r}));
      ex_r[5] <= ex_r[4];
      ez_r[5] <= ez_r[4];
    end
  end

  // P6: output register
  logic signed [31:0]     yf;
  logic signed [PT_W-1:0] ey_r;
  assign yf = cond5_r ? (top5_r + 32'(pr5_r >>> 16)) : y5_r;

  always_ff @(posedge clk) begin
    if (en[6]) begin
      ex_r[6] <= ex_r[5];
      ez_r[6] <= ez_r[5];
      ey_r    <= emit(yf);
    end
  end

  assign point_x = ex_r[6];
  assign point_y = ey_r;
  assign point_z = ez_r[6];

endmodule

>>> rtl/fbm_value_noise_displace_core.sv
`timescale 1ns / 1ps
// Channel  Dir  Handshake       Payload
// in_ch    in   valid/ready     dir_x, dir_y, dir_z (Q1.14)
// out_ch   out  valid/ready     point_x, point_y, point_z (Q8.8, 18 bit)
// cfg_*    in   APB write/read  noise_seed @0x0, rock_size @0x4, flatness @0x8
//
// One transaction per cycle sustained while out_ch accepts; data passes through
// one pipelined cell per octave, then through the radius stage.
// Every stage stalls on its own: a stage loads when it is empty or its
// successor loads, so bubbles close up under output backpressure.
// Synchronous active-low reset clears all valid bits and loads the register
// reset values.
module fbm_value_noise_displace_core import fbmv_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  fbmv_in_if.sink           in_ch,
  fbmv_out_if.source        out_ch,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  logic [31:0] seed_r;
  logic [15:0] size_r;
  logic [16:0] flat_r;
  logic        cfg_wr;
  logic [1:0]  cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = cfg_paddr[3:2];

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= SEED_RST;
      size_r <= SIZE_RST;
      flat_r <= FLAT_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        CFG_SEED: seed_r <= cfg_pwdata;
        CFG_SIZE: size_r <= cfg_pwdata[15:0];
        CFG_FLAT: flat_r <= cfg_pwdata[16:0];
        default:  ;
      endcase
    end
  end

  // register reads
  always_comb begin
    unique case (cfg_idx)
      CFG_SEED: cfg_prdata = seed_r;
      CFG_SIZE: cfg_prdata = {16'b0, size_r};
      CFG_FLAT: cfg_prdata = {15'b0, flat_r};
      default:  cfg_prdata = '0;
    endcase
  end

  // octave cell chain
  cell_data_t cd [OCTAVES+1];
  logic       cv [OCTAVES+1];
  logic       cr [OCTAVES+1];

  assign cd[0].dir_x = in_ch.dir_x;
  assign cd[0].dir_y = in_ch.dir_y;
  assign cd[0].dir_z = in_ch.dir_z;
  assign cd[0].sum   = '0;
  assign cv[0]       = in_ch.valid;
  assign in_ch.ready = cr[0];

  for (genvar g = 0; g < OCTAVES; g++) begin : g_oct
    fbmv_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .oct_idx  (OCT_W'(g)),
      .seed     (seed_r),
      .up_valid (cv[g]),
      .up_ready (cr[g]),
      .up_data  (cd[g]),
      .dn_valid (cv[g+1]),
      .dn_ready (cr[g+1]),
      .dn_data  (cd[g+1])
    );
  end

  // radius, squash and output register
  fbmv_post u_post (
    .clk       (clk),
    .rst_n     (rst_n),
    .rock_size (size_r),
    .flatness  (flat_r),
    .up_valid  (cv[OCTAVES]),
    .up_ready  (cr[OCTAVES]),
    .up_data   (cd[OCTAVES]),
    .dn_valid  (out_ch.valid),
    .dn_ready  (out_ch.ready),
    .point_x   (out_ch.point_x),
    .point_y   (out_ch.point_y),
    .point_z   (out_ch.point_z)
  );

`ifndef ASSERT_OFF
  a_seed_wr: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr && cfg_idx == CFG_SEED |=> seed_r == $past(cfg_pwdata))
    else $error("seed register write lost");

  a_zero_size: assert property (@(posedge clk)
    out_ch.valid && size_r == 16'd0 |->
      out_ch.point_x == '0 && out_ch.point_y == '0 && out_ch.point_z == '0)
    else $error("nonzero point with zero size");

  a_rst_clear: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("output valid after reset");
`endif

endmodule
